@@ hdl/ldcm_pkg.sv @@
`timescale 1ns / 1ps
package ldcm_pkg;

  localparam int GRID_LOG2 = 9;
  localparam int FRAC = 16;
  localparam int PIX_W = 9;
  localparam int NUM_STAGES = 14;

  // register indexes on the config channel
  localparam logic [2:0] REG_K_ZERO      = 3'd0;
  localparam logic [2:0] REG_K_ONE       = 3'd1;
  localparam logic [2:0] REG_K_TWO       = 3'd2;
  localparam logic [2:0] REG_K_THREE     = 3'd3;
  localparam logic [2:0] REG_LENS_OFFSET = 3'd4;
  localparam logic [2:0] REG_ASPECT      = 3'd5;
  localparam logic [2:0] REG_INV_ASPECT  = 3'd6;

  // coordinates that ride along the Horner stages
  typedef struct packed {
    logic signed [18:0] sx;
    logic signed [18:0] sy;
    logic signed [18:0] off;
    logic [21:0]        r2;
  } carry_t;

  typedef struct packed {
    logic mul;
    logic add;
  } step_en_t;

  // pixel centre mapped to [-1,1] in Q16
  function automatic logic signed [17:0] centre(input logic [PIX_W-1:0] p);
    logic [17:0] t;
    t = 18'({p, 1'b1}) << (FRAC - GRID_LOG2);
    return $signed(t) - 18'sd65536;
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [19:0] sat_s20(input logic signed [39:0] v);
    if (v > 40'sd524287) return 20'sh7FFFF;
    else if (v < -40'sd524288) return 20'sh80000;
    else return v[19:0];
  endfunction

endpackage

@@ hdl/ldcm_horner_step.sv @@
`timescale 1ns / 1ps
module ldcm_horner_step (
  input  logic                  clk,
  input  ldcm_pkg::step_en_t    en,
  input  logic signed [19:0]    k,
  input  logic signed [31:0]    d_in,
  input  ldcm_pkg::carry_t      carry_in,
  output logic signed [31:0]    d_out,
  output ldcm_pkg::carry_t      carry_out
);

  logic signed [54:0] prod;
  ldcm_pkg::carry_t   carry_mid;

  // stage a: r2 * d
  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod      <= 55'($signed({1'b0, carry_in.r2})) * 55'(d_in);
      carry_mid <= carry_in;
    end
  end

  // stage b: k + round(r2 * d), saturated
  always_ff @(posedge clk) begin
    if (en.add) begin
      d_out     <= ldcm_pkg::sat_s32(40'(k) + 40'((prod + 55'sd32768) >>> 16));
      carry_out <= carry_mid;
    end
  end

endmodule

@@ hdl/lens_distortion_coord_map_unit.sv @@
`timescale 1ns / 1ps
// Radial lens distortion coordinate mapper.
// s_axis carries one grid pixel per word: tdata holds pixel_x and pixel_y,
// tuser holds the eye select. m_axis returns one word per input word with
// the source texture coordinate (src_u, src_v), signed Q16, saturated.
// The cfg channel writes the seven coefficient/geometry registers by index;
// cfg_ready is always high, and writes are meant to happen while no pixel
// is in flight. Unknown indexes are ignored.
// The datapath is a 14-stage pipeline; an accepted word passes through it
// to the output register in stage 13. One word per cycle is sustained while
// m_axis is ready. Stage depth is set by the multipliers: one per stage, the
// three Horner steps each taking a multiply stage and an add/saturate stage.
// Each stage has its own valid bit and advances when the next one is empty
// or moving, so bubbles close up and s_axis keeps accepting while m_axis is
// stalled until the pipeline is full. Nothing is dropped or repeated.
// Synchronous reset empties the pipeline and loads the default registers
// (unity scale, no offset, aspect 1.0).
module lens_distortion_coord_map_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [8:0] pixel_x, [17:9] pixel_y, [23:18] zero
  input  logic        s_axis_tuser,   // [0] eye
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [19:0] src_u, [39:20] src_v
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int N = ldcm_pkg::NUM_STAGES;

  logic signed [19:0] k_zero, k_one, k_two, k_three;
  logic signed [17:0] lens_offset;
  logic [17:0]        aspect, inv_aspect;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_zero      <= 20'sd65536;
      k_one       <= '0;
      k_two       <= '0;
      k_three     <= '0;
      lens_offset <= '0;
      aspect      <= 18'd65536;
      inv_aspect  <= 18'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ldcm_pkg::REG_K_ZERO:      k_zero      <= cfg_data;
        ldcm_pkg::REG_K_ONE:       k_one       <= cfg_data;
        ldcm_pkg::REG_K_TWO:       k_two       <= cfg_data;
        ldcm_pkg::REG_K_THREE:     k_three     <= cfg_data;
        ldcm_pkg::REG_LENS_OFFSET: lens_offset <= cfg_data[17:0];
        ldcm_pkg::REG_ASPECT:      aspect      <= cfg_data[17:0];
        ldcm_pkg::REG_INV_ASPECT:  inv_aspect  <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // stage control
  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !vld[N-1] || m_axis_tready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 0: centre, lens shift, y times inverse aspect
  logic signed [18:0] off_in;
  logic signed [18:0] s0_sx, s0_off;
  logic signed [36:0] s0_syp;

  assign off_in = s_axis_tuser ? 19'(lens_offset) : -19'(lens_offset);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_sx  <= 19'(ldcm_pkg::centre(s_axis_tdata[8:0])) + off_in;
      s0_syp <= 37'(ldcm_pkg::centre(s_axis_tdata[17:9])) *
                37'($signed({1'b0, inv_aspect}));
      s0_off <= off_in;
    end
  end

  // stage 1: round y
  logic signed [18:0] s1_sx, s1_sy, s1_off;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sx  <= s0_sx;
      s1_sy  <= 19'((s0_syp + 37'sd32768) >>> 16);
      s1_off <= s0_off;
    end
  end

  // stage 2: squares
  logic signed [37:0] s2_sxx, s2_syy;
  logic signed [18:0] s2_sx, s2_sy, s2_off;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_sxx <= 38'(s1_sx) * 38'(s1_sx);
      s2_syy <= 38'(s1_sy) * 38'(s1_sy);
      s2_sx  <= s1_sx;
      s2_sy  <= s1_sy;
      s2_off <= s1_off;
    end
  end

  // stage 3: r2, always nonnegative and well under 2^22 for these ranges
  ldcm_pkg::carry_t s3_c;
  logic signed [38:0] r2_sum;

  assign r2_sum = 39'(s2_sxx) + 39'(s2_syy) + 39'sd32768;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_c.sx  <= s2_sx;
      s3_c.sy  <= s2_sy;
      s3_c.off <= s2_off;
      s3_c.r2  <= r2_sum[37:16];
    end
  end

  // stages 4..9: Horner evaluation of the scale factor
  ldcm_pkg::step_en_t h_en [3];
  logic signed [31:0] d1, d2, d3;
  ldcm_pkg::carry_t   c1, c2, c3;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      h_en[j].mul = en[4 + 2*j];
      h_en[j].add = en[5 + 2*j];
    end
  end

  ldcm_horner_step u_step_three (
    .clk(clk), .en(h_en[0]), .k(k_two), .d_in(32'(k_three)),
    .carry_in(s3_c), .d_out(d1), .carry_out(c1)
  );

  ldcm_horner_step u_step_two (
    .clk(clk), .en(h_en[1]), .k(k_one), .d_in(d1),
    .carry_in(c1), .d_out(d2), .carry_out(c2)
  );

  ldcm_horner_step u_step_one (
    .clk(clk), .en(h_en[2]), .k(k_zero), .d_in(d2),
    .carry_in(c2), .d_out(d3), .carry_out(c3)
  );

  // stage 10: scale both coordinates
  logic signed [50:0] s10_px, s10_py;
  logic signed [18:0] s10_off;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_px  <= 51'(c3.sx) * 51'(d3);
      s10_py  <= 51'(c3.sy) * 51'(d3);
      s10_off <= c3.off;
    end
  end

  // stage 11: round, saturate, undo the lens shift
  logic signed [32:0] s11_sx;
  logic signed [31:0] s11_sy;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_sx <= 33'(ldcm_pkg::sat_s32(40'((s10_px + 51'sd32768) >>> 16))) - 33'(s10_off);
      s11_sy <= ldcm_pkg::sat_s32(40'((s10_py + 51'sd32768) >>> 16));
    end
  end

  // stage 12: undo the aspect scaling
  logic signed [50:0] s12_pv;
  logic signed [32:0] s12_sx;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s12_pv <= 51'(s11_sy) * 51'($signed({1'b0, aspect}));
      s12_sx <= s11_sx;
    end
  end

  // stage 13: back to [0,1] and output register
  logic signed [39:0] u_half, v_round, v_half;

  always_comb begin
    u_half  = (40'(s12_sx) + 40'sd65537) >>> 1;
    v_round = 40'((s12_pv + 51'sd32768) >>> 16);
    v_half  = (v_round + 40'sd65537) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en[13]) begin
      m_axis_tdata <= {ldcm_pkg::sat_s20(v_half), ldcm_pkg::sat_s20(u_half)};
    end
  end

endmodule

@@ hdl/ldcm_checker.sv @@
`timescale 1ns / 1ps
module ldcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // a stalled output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // with the output stage empty there is always room upstream
  a_room: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output stage");

  // a word reaching an empty output stage went through without a stall
  a_latency: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid ##1 m_axis_tvalid |->
      $past(s_axis_tvalid && s_axis_tready, ldcm_pkg::NUM_STAGES))
    else $error("output word without a matching input word");

endmodule

bind lens_distortion_coord_map_unit ldcm_checker u_ldcm_checker (.*);
